// ----- hdl/vdd_pkg.sv -----
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared types and constants for the vibration driving detector.
// ----------------------------------------------------------------------------
package vdd_pkg;

    localparam int AXIS_W     = 16;
    localparam int LEVEL_W    = 24;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 32;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // radix-4 squaring steps and one root bit per step
    localparam int SQ_STEPS = AXIS_W / 2;
    localparam int RT_STEPS = LEVEL_W;

    localparam logic [7:0]          FAIL_LIMIT = 8'd3;
    localparam logic [LEVEL_W-1:0]  TREND_MIN  = 24'd8389;
    localparam logic signed [11:0]  BASE_W     = 12'sd1966;
    localparam logic signed [36:0]  ROUND_HALF = 37'sd32768;

    localparam logic [15:0]         RST_SAMPLE_INTERVAL = 16'd20;
    localparam logic [LEVEL_W-1:0]  RST_MOTION_THR      = 24'd209715;
    localparam logic [LEVEL_W-1:0]  RST_VARIANCE_THR    = 24'd83886;
    localparam logic [15:0]         RST_PERSIST         = 16'd2000;
    localparam logic [LEVEL_W-1:0]  RST_HOLD            = 24'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_MOTION_THR      = 3'd1,
        REG_VARIANCE_THR    = 3'd2,
        REG_PERSIST         = 3'd3,
        REG_HOLD            = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAG,
        ST_BASE,
        ST_BLEND,
        ST_VIB,
        ST_ENV,
        ST_TEST,
        ST_GATE,
        ST_DRIVE,
        ST_DONE
    } vdd_state_t;

    typedef enum logic [1:0] {
        MG_IDLE,
        MG_SQUARE,
        MG_ROOT
    } mag_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mag_status_t;

endpackage

// ----- hdl/vibration_driving_detector.sv -----
// ----------------------------------------------------------------------------
// vibration_driving_detector
// Accelerometer vibration tracker with persistence and hold timing.
// ----------------------------------------------------------------------------
// Takes one request per tick and returns one result for each. A tick that is
// skipped (interval not elapsed, failed read, or block unavailable) goes from
// ST_CHECK straight to ST_DONE. A processed sample is paced by the serial
// magnitude unit: 8 radix-4 squaring steps and 24 square-root steps, one
// result bit per cycle, followed by 7 filter and timer steps. A finished
// result sits in the output register, so the next request can be accepted
// while it waits. Configuration writes take effect at once and are meant
// for idle periods.
module vibration_driving_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
    input  logic [vdd_pkg::S_TDATA_W-1:0]      s_tdata,
    // read_ok
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // driving[0], available[1], sampled[2], vibration_level[26:3], zero pad
    output logic [vdd_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [vdd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vdd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import vdd_pkg::*;

    vdd_state_t          state_reg, state_next;

    logic [15:0]         sample_interval_reg;
    logic [LEVEL_W-1:0]  motion_thr_reg;
    logic [LEVEL_W-1:0]  variance_thr_reg;
    logic [15:0]         persist_reg;
    logic [LEVEL_W-1:0]  hold_reg;

    logic                is_available_reg;
    logic                is_driving_reg;
    logic                baseline_valid_reg;
    logic [LEVEL_W-1:0]  baseline_reg;
    logic [LEVEL_W-1:0]  envelope_reg;
    logic                gates_open_reg;
    logic [TIME_W-1:0]   gates_since_reg;
    logic [TIME_W-1:0]   last_sample_reg;
    logic [TIME_W-1:0]   last_motion_reg;
    logic [7:0]          fail_count_reg;
    logic                m_valid_reg;

    logic [TIME_W-1:0]   now_reg;
    logic                ok_reg;
    logic [AXIS_W-1:0]   abs_x_reg, abs_y_reg, abs_z_reg;
    logic signed [36:0]  prod_reg;
    logic [LEVEL_W-1:0]  vib_reg;
    logic [LEVEL_W-1:0]  var_reg;
    logic [LEVEL_W-1:0]  env_prev_reg;
    logic                pass_reg;
    logic                sampled_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                accept, elapsed, go_sample, mag_start, out_load;
    logic [7:0]          fail_inc;
    mag_status_t         mag_stat;
    logic [LEVEL_W-1:0]  mag;
    logic [LEVEL_W-1:0]  base_cur;
    logic signed [24:0]  base_diff;
    logic signed [36:0]  base_prod;
    logic [25:0]         env_sum;
    logic                rising;
    logic [TIME_W-1:0]   since_eff;

    function automatic logic [LEVEL_W-1:0] absdiff(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [AXIS_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
        axis_abs = v[AXIS_W-1] ? (~v + 16'd1) : v;
    endfunction

    vdd_mag u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mag_start),
        .abs_x   (abs_x_reg),
        .abs_y   (abs_y_reg),
        .abs_z   (abs_z_reg),
        .status  (mag_stat),
        .mag     (mag)
    );

    always_comb begin
        accept    = s_tvalid && s_tready;
        elapsed   = (now_reg - last_sample_reg) >= {16'd0, sample_interval_reg};
        go_sample = is_available_reg && elapsed && ok_reg;
        fail_inc  = (fail_count_reg == 8'hFF) ? fail_count_reg : fail_count_reg + 8'd1;
        base_cur  = baseline_valid_reg ? baseline_reg : mag;
        base_diff = $signed({1'b0, mag}) - $signed({1'b0, base_cur});
        base_prod = base_diff * BASE_W + ROUND_HALF;
        env_sum   = {2'b00, envelope_reg} + {1'b0, envelope_reg, 1'b0}
                  + {2'b00, vib_reg} + 26'd2;
        rising    = (envelope_reg > env_prev_reg)
                 && ((envelope_reg - env_prev_reg) > TREND_MIN);
        since_eff = gates_open_reg ? gates_since_reg : now_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CHECK;
            ST_CHECK: state_next = go_sample ? ST_MAG : ST_DONE;
            ST_MAG:   if (mag_stat.done) state_next = ST_BASE;
            ST_BASE:  state_next = ST_BLEND;
            ST_BLEND: state_next = ST_VIB;
            ST_VIB:   state_next = ST_ENV;
            ST_ENV:   state_next = ST_TEST;
            ST_TEST:  state_next = ST_GATE;
            ST_GATE:  state_next = ST_DRIVE;
            ST_DRIVE: state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        mag_start = (state_reg == ST_CHECK) && go_sample;
        out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            sample_interval_reg <= RST_SAMPLE_INTERVAL;
            motion_thr_reg      <= RST_MOTION_THR;
            variance_thr_reg    <= RST_VARIANCE_THR;
            persist_reg         <= RST_PERSIST;
            hold_reg            <= RST_HOLD;
            is_available_reg    <= 1'b1;
            is_driving_reg      <= 1'b0;
            baseline_valid_reg  <= 1'b0;
            baseline_reg        <= '0;
            envelope_reg        <= '0;
            gates_open_reg      <= 1'b0;
            gates_since_reg     <= '0;
            last_sample_reg     <= '0;
            last_motion_reg     <= '0;
            fail_count_reg      <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_wdata[15:0];
                    REG_MOTION_THR:      motion_thr_reg      <= cfg_wdata;
                    REG_VARIANCE_THR:    variance_thr_reg    <= cfg_wdata;
                    REG_PERSIST:         persist_reg         <= cfg_wdata[15:0];
                    REG_HOLD:            hold_reg            <= cfg_wdata;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CHECK: begin
                    if (!is_available_reg) begin
                        is_driving_reg <= 1'b0;
                    end else if (elapsed) begin
                        last_sample_reg <= now_reg;
                        if (!ok_reg) begin
                            fail_count_reg <= fail_inc;
                            if (fail_inc >= FAIL_LIMIT) begin
                                is_available_reg <= 1'b0;
                                is_driving_reg   <= 1'b0;
                            end
                        end else begin
                            fail_count_reg <= '0;
                        end
                    end
                end
                ST_BASE: begin
                    baseline_reg       <= base_cur;
                    baseline_valid_reg <= 1'b1;
                end
                ST_BLEND: begin
                    baseline_reg <= baseline_reg + {{3{prod_reg[36]}}, prod_reg[36:16]};
                end
                ST_ENV: begin
                    envelope_reg <= env_sum[25:2];
                end
                ST_GATE: begin
                    if (pass_reg) begin
                        gates_open_reg  <= 1'b1;
                        gates_since_reg <= since_eff;
                        if ((now_reg - since_eff) >= {16'd0, persist_reg}) begin
                            last_motion_reg <= now_reg;
                        end
                    end else begin
                        gates_open_reg  <= 1'b0;
                        gates_since_reg <= '0;
                    end
                end
                ST_DRIVE: begin
                    is_driving_reg <= (now_reg - last_motion_reg) <= {8'd0, hold_reg};
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg   <= s_tdata[31:0];
            ok_reg    <= s_tuser;
            abs_x_reg <= axis_abs(s_tdata[47:32]);
            abs_y_reg <= axis_abs(s_tdata[63:48]);
            abs_z_reg <= axis_abs(s_tdata[79:64]);
        end
        if (state_reg == ST_CHECK) begin
            sampled_reg <= go_sample;
        end
        if (state_reg == ST_BASE) begin
            prod_reg <= base_prod;
        end
        if (state_reg == ST_VIB) begin
            vib_reg <= absdiff(mag, baseline_reg);
        end
        if (state_reg == ST_ENV) begin
            env_prev_reg <= envelope_reg;
            var_reg      <= absdiff(vib_reg, envelope_reg);
        end
        if (state_reg == ST_TEST) begin
            pass_reg <= (envelope_reg > motion_thr_reg)
                     && (var_reg > variance_thr_reg) && rising;
        end
        if (out_load) begin
            m_data_reg <= {5'd0, envelope_reg, sampled_reg, is_available_reg,
                           is_driving_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // once unavailable, the block stays so until reset
    a_avail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !is_available_reg |=> !is_available_reg)
        else $error("available rose without reset");

    a_unavail_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !is_available_reg |-> !is_driving_reg)
        else $error("driving while unavailable");

    a_mag_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_stat.done |-> state_reg == ST_MAG)
        else $error("magnitude finished outside wait state");

    a_mag_busy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_stat.busy |-> state_reg == ST_MAG)
        else $error("magnitude unit busy outside wait state");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && !s_tvalid |=> state_reg == ST_IDLE)
        else $error("left idle without a request");

endmodule

// ----- hdl/vdd_mag.sv -----
// ----------------------------------------------------------------------------
// vdd_mag
// Serial vector magnitude: radix-4 sum of squares, then a bit-serial
// restoring square root of sum * 65536 (Q8 result).
// ----------------------------------------------------------------------------
module vdd_mag (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [vdd_pkg::AXIS_W-1:0]   abs_x,
    input  logic [vdd_pkg::AXIS_W-1:0]   abs_y,
    input  logic [vdd_pkg::AXIS_W-1:0]   abs_z,
    output vdd_pkg::mag_status_t         status,
    output logic [vdd_pkg::LEVEL_W-1:0]  mag
);
    import vdd_pkg::*;

    mag_state_t          state_reg, state_next;
    logic [4:0]          cnt_reg;
    logic                done_reg;
    logic [AXIS_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [AXIS_W-1:0]   mx_reg, my_reg, mz_reg;
    logic [36:0]         prod_reg, prod_next;
    logic [47:0]         rad_reg;
    logic [25:0]         rem_reg;
    logic [LEVEL_W-1:0]  root_reg;

    logic                sq_step, rt_step, sq_last, rt_last;
    logic [19:0]         digit_sum;
    logic [20:0]         hi_sum;
    logic [25:0]         rem_sh, trial;

    function automatic logic [17:0] digit_mul(input logic [1:0] d, input logic [15:0] a);
        logic [17:0] a18;
        a18 = {2'b00, a};
        digit_mul = (d[0] ? a18 : 18'd0) + (d[1] ? {a18[16:0], 1'b0} : 18'd0);
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MG_IDLE:   if (start) state_next = MG_SQUARE;
            MG_SQUARE: if (sq_last) state_next = MG_ROOT;
            MG_ROOT:   if (rt_last) state_next = MG_IDLE;
            default:   state_next = MG_IDLE;
        endcase
    end

    // step controls
    always_comb begin
        sq_step = (state_reg == MG_SQUARE);
        rt_step = (state_reg == MG_ROOT);
        sq_last = sq_step && (cnt_reg == 5'(SQ_STEPS - 1));
        rt_last = rt_step && (cnt_reg == 5'(RT_STEPS - 1));
    end

    // accumulate three digit products at the top, shift two bits down
    always_comb begin
        digit_sum = {2'b00, digit_mul(mx_reg[1:0], ax_reg)}
                  + {2'b00, digit_mul(my_reg[1:0], ay_reg)}
                  + {2'b00, digit_mul(mz_reg[1:0], az_reg)};
        hi_sum    = prod_reg[36:16] + {1'b0, digit_sum};
        prod_next = {2'b00, hi_sum, prod_reg[15:2]};
        rem_sh    = {rem_reg[23:0], rad_reg[47:46]};
        trial     = {root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MG_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= rt_last;
            if (state_next != state_reg) begin
                cnt_reg <= '0;
            end else if (sq_step || rt_step) begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == MG_IDLE && start) begin
            ax_reg   <= abs_x;
            ay_reg   <= abs_y;
            az_reg   <= abs_z;
            mx_reg   <= abs_x;
            my_reg   <= abs_y;
            mz_reg   <= abs_z;
            prod_reg <= '0;
        end
        if (sq_step) begin
            prod_reg <= prod_next;
            mx_reg   <= {2'b00, mx_reg[AXIS_W-1:2]};
            my_reg   <= {2'b00, my_reg[AXIS_W-1:2]};
            mz_reg   <= {2'b00, mz_reg[AXIS_W-1:2]};
        end
        if (sq_last) begin
            rad_reg  <= {prod_next[SUM_W-1:0], 16'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (rt_step) begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[LEVEL_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[LEVEL_W-2:0], 1'b0};
            end
        end
    end

    assign status.busy = (state_reg != MG_IDLE);
    assign status.done = done_reg;
    assign mag         = root_reg;

endmodule
